FILE: hdl/rcss_pkg.sv
// ----------------------------------------------------------------------------
// rcss_pkg - shared types and constants of the stick setpoint shaper
// Field widths, stick and throttle constants, mode and register codes.
// ----------------------------------------------------------------------------
package rcss_pkg;

	// field widths
	localparam int PULSE_W = 12;
	localparam int MODE_W  = 2;
	localparam int THR_W   = 17;
	localparam int SP_W    = 20;
	localparam int DB_W    = 9;
	localparam int EXPO_W  = 16;
	localparam int ANGLE_W = 8;
	localparam int RATE_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// width of the value fed to the divide-by-125 unit
	localparam int DIVX_W = 23;
	localparam int Q_W    = 16;

	// pulse constants in microseconds
	localparam logic [PULSE_W-1:0] PULSE_MIN = 12'd1000;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd2000;
	localparam logic [PULSE_W:0]   PULSE_MID = 13'd1500;
	localparam logic [DB_W-1:0]    HALF_SPAN = 9'd500;

	// rounding bias: (a*32768 + 250) / 500 == (a*8192 + 62) / 125
	localparam logic [DIVX_W-1:0] DIV_BIAS = 23'd62;

	// reset values of the registers
	localparam logic [DB_W-1:0]    DB_RST    = 9'd20;
	localparam logic [EXPO_W-1:0]  EXPO_RST  = 16'd22938;
	localparam logic [ANGLE_W-1:0] ANGLE_RST = 8'd45;
	localparam logic [RATE_W-1:0]  RATE_RST  = 11'd400;

	// flight mode codes; code 3 behaves as acro
	typedef enum logic [MODE_W-1:0] {
		MODE_MANUAL = 2'd0,
		MODE_STAB   = 2'd1,
		MODE_ACRO   = 2'd2,
		MODE_ACRO_X = 2'd3
	} flight_mode_t;

	// register index codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND = 2'd0,
		REG_EXPO     = 2'd1,
		REG_ANGLE    = 2'd2,
		REG_RATE     = 2'd3
	} cfg_reg_t;

	// per-lane control that rides along with the stick value
	typedef struct packed {
		logic [RATE_W-1:0] scale;  // full-stick scale for this axis
		logic              zero;   // manual mode: force setpoint to zero
	} lane_ctl_t;

endpackage

FILE: hdl/rcss_div125.sv
// ----------------------------------------------------------------------------
// rcss_div125 - pipelined divide by 125
// Reciprocal multiply gives a quotient low by at most one; one compare and
// add fixes it. Two register stages.
// ----------------------------------------------------------------------------
module rcss_div125 (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rcss_pkg::DIVX_W-1:0] x,
	output logic [rcss_pkg::Q_W-1:0]    q
);
	import rcss_pkg::*;

	// floor(2^29 / 125)
	localparam int RECIP_SH = 29;
	localparam logic [22:0] RECIP = 23'((64'd1 << RECIP_SH) / 125);
	localparam logic [DIVX_W:0] DIVISOR = 24'd125;

	logic [DIVX_W+22:0] prod;
	logic [DIVX_W-1:0]  x_s2;
	logic [Q_W-1:0]     qe_s2;
	logic [DIVX_W:0]    qmul;
	logic [DIVX_W:0]    rem;

	assign prod = {23'd0, x} * {{DIVX_W{1'b0}}, RECIP};

	// estimate
	always_ff @(posedge clk) begin
		if (en) begin
			x_s2  <= x;
			qe_s2 <= prod[RECIP_SH+Q_W-1:RECIP_SH];
		end
	end

	// remainder check and correction
	assign qmul = {{(DIVX_W+1-Q_W){1'b0}}, qe_s2} * DIVISOR;
	assign rem  = {1'b0, x_s2} - qmul;

	always_ff @(posedge clk) begin
		if (en) begin
			q <= (rem >= DIVISOR) ? qe_s2 + 16'd1 : qe_s2;
		end
	end

endmodule

FILE: hdl/rcss_lane.sv
// ----------------------------------------------------------------------------
// rcss_lane - one stick axis
// Center, deadband, normalize to Q1.15, cubic expo, scale to Q12.8.
// Eight register stages from the pulse to the signed setpoint.
// ----------------------------------------------------------------------------
module rcss_lane (
	input  logic                           clk,
	input  logic                           en,
	input  logic [rcss_pkg::PULSE_W-1:0]   pulse,
	input  rcss_pkg::lane_ctl_t            ctl,
	input  logic [rcss_pkg::DB_W-1:0]      deadband,
	input  logic [rcss_pkg::EXPO_W-1:0]    expo,
	output logic signed [rcss_pkg::SP_W-1:0] setpoint
);
	import rcss_pkg::*;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// stage 1: center, magnitude, deadband, saturation
	logic signed [PULSE_W:0] v;
	logic [PULSE_W-1:0]      a_full;
	logic [DB_W-1:0]         a_lim;
	logic                    neg_s1;
	lane_ctl_t               ctl_s1;
	logic [DIVX_W-1:0]       x_s1;

	assign v      = $signed({1'b0, pulse}) - $signed(PULSE_MID);
	assign a_full = v[PULSE_W] ? PULSE_W'(-v) : v[PULSE_W-1:0];

	always_comb begin
		if (a_full < {3'd0, deadband})
			a_lim = '0;
		else if (a_full > {3'd0, HALF_SPAN})
			a_lim = HALF_SPAN;
		else
			a_lim = a_full[DB_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= v[PULSE_W];
			ctl_s1 <= ctl;
			x_s1   <= {1'b0, a_lim, 13'd0} + DIV_BIAS;
		end
	end

	// stages 2..3: normalized magnitude m = x / 125
	logic [Q_W-1:0] m_s3;
	logic           neg_s2, neg_s3;
	lane_ctl_t      ctl_s2, ctl_s3;

	rcss_div125 u_div (
		.clk (clk),
		.en  (en),
		.x   (x_s1),
		.q   (m_s3)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= neg_s1;
			ctl_s2 <= ctl_s1;
			neg_s3 <= neg_s2;
			ctl_s3 <= ctl_s2;
		end
	end

	// stage 4: d = 1 - m^2 in Q1.30
	logic [31:0]    msq;
	logic [30:0]    d_s4;
	logic [Q_W-1:0] m_s4;
	logic           neg_s4;
	lane_ctl_t      ctl_s4;

	assign msq = m_s3 * m_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4   <= ONE_Q30 - msq[30:0];
			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
			ctl_s4 <= ctl_s3;
		end
	end

	// stage 5: f = 1 - E*d
	logic [46:0]    ed;
	logic [30:0]    f_s5;
	logic [Q_W-1:0] m_s5;
	logic           neg_s5;
	lane_ctl_t      ctl_s5;

	assign ed = {15'd0, d_s4} * {31'd0, expo};

	always_ff @(posedge clk) begin
		if (en) begin
			f_s5   <= ONE_Q30 - ed[46:16];
			m_s5   <= m_s4;
			neg_s5 <= neg_s4;
			ctl_s5 <= ctl_s4;
		end
	end

	// stage 6: y = m * f, back to Q1.15
	logic [46:0]    mf;
	logic [Q_W-1:0] y_s6;
	logic           neg_s6;
	lane_ctl_t      ctl_s6;

	assign mf = {31'd0, m_s5} * {16'd0, f_s5};

	always_ff @(posedge clk) begin
		if (en) begin
			y_s6   <= mf[45:30];
			neg_s6 <= neg_s5;
			ctl_s6 <= ctl_s5;
		end
	end

	// stage 7: magnitude in Q12.8, round half up
	logic [26:0]     ys;
	logic [27:0]     ys_rnd;
	logic [SP_W-1:0] mag_s7;
	logic            neg_s7;
	logic            zero_s7;

	assign ys     = {11'd0, y_s6} * {16'd0, ctl_s6.scale};
	assign ys_rnd = {1'b0, ys} + 28'd64;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s7  <= ys_rnd[26:7];
			neg_s7  <= neg_s6;
			zero_s7 <= ctl_s6.zero;
		end
	end

	// stage 8: apply sign, manual mode forces zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s7)
				setpoint <= '0;
			else if (neg_s7)
				setpoint <= $signed(-mag_s7);
			else
				setpoint <= $signed(mag_s7);
		end
	end

endmodule

FILE: hdl/rcss_throttle.sv
// ----------------------------------------------------------------------------
// rcss_throttle - throttle pulse to Q1.16 level
// Linear map of 1000..2000 us onto 0..65536 with clamping, delayed to line
// up with the stick lanes (eight register stages).
// ----------------------------------------------------------------------------
module rcss_throttle (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rcss_pkg::PULSE_W-1:0]  pulse,
	output logic [rcss_pkg::THR_W-1:0]    level
);
	import rcss_pkg::*;

	localparam logic [THR_W-1:0] FULL = 17'h10000;

	logic [PULSE_W-1:0] t;
	logic [DIVX_W-1:0]  x_s1;
	logic               lo_s1, hi_s1, lo_s2, hi_s2, lo_s3, hi_s3;
	logic [Q_W-1:0]     q_s3;
	logic [THR_W-1:0]   lvl_s4, lvl_s5, lvl_s6, lvl_s7;

	assign t = pulse - PULSE_MIN;

	// stage 1: offset from the low end, clamp flags
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= (pulse <= PULSE_MIN);
			hi_s1 <= (pulse >= PULSE_MAX);
			x_s1  <= {t[9:0], 13'd0} + DIV_BIAS;
		end
	end

	// stages 2..3: divide
	rcss_div125 u_div (
		.clk (clk),
		.en  (en),
		.x   (x_s1),
		.q   (q_s3)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
			lo_s3 <= lo_s2;
			hi_s3 <= hi_s2;
		end
	end

	// stage 4: clamp; stages 5..8 align with the lanes
	always_ff @(posedge clk) begin
		if (en) begin
			if (hi_s3)
				lvl_s4 <= FULL;
			else if (lo_s3)
				lvl_s4 <= '0;
			else
				lvl_s4 <= {1'b0, q_s3};
			lvl_s5 <= lvl_s4;
			lvl_s6 <= lvl_s5;
			lvl_s7 <= lvl_s6;
			level  <= lvl_s7;
		end
	end

endmodule

FILE: hdl/rc_stick_setpoint_shaper_top.sv
// Each input beat goes through the lane pipelines and the output register.
// Throughput: one frame per cycle; the three stick lanes and the throttle
// unit are fully pipelined, a stall at the output holds the whole pipe.
// Reset: arst_n clears the valid chain and output valid and loads the
// registers with deadband 20, expo 22938, max angle 45, max rate 400.
// ----------------------------------------------------------------------------
// rc_stick_setpoint_shaper_top - RC stick setpoint shaper
// Three parallel stick lanes plus a throttle unit; the merge stage packs
// throttle, setpoints and the valid flag into one output beat.
// ----------------------------------------------------------------------------
module rc_stick_setpoint_shaper_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// input frame
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// roll_pulse[11:0], pitch_pulse[23:12], yaw_pulse[35:24], throttle_pulse[47:36]
	input  logic [47:0]                        s_tdata,
	// flight_mode[1:0]
	input  logic [1:0]                         s_tuser,
	// output setpoints
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// throttle_level[16:0], roll_setpoint[36:17], pitch_setpoint[56:37],
	// yaw_rate_setpoint[76:57], zero fill[79:77]
	output logic [79:0]                        m_tdata,
	// setpoints_valid[0]
	output logic [0:0]                         m_tuser,
	// register writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rcss_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcss_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rcss_pkg::*;

	localparam int DEPTH = 8;

	// configuration registers
	logic [DB_W-1:0]    deadband_q;
	logic [EXPO_W-1:0]  expo_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [RATE_W-1:0]  rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DB_RST;
			expo_q     <= EXPO_RST;
			angle_q    <= ANGLE_RST;
			rate_q     <= RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEADBAND: deadband_q <= cfg_data[DB_W-1:0];
				REG_EXPO:     expo_q     <= cfg_data[EXPO_W-1:0];
				REG_ANGLE:    angle_q    <= cfg_data[ANGLE_W-1:0];
				REG_RATE:     rate_q     <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipe advances unless a finished beat is stuck at the output
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// valid chain for the pipeline stages
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], s_tvalid};
		end
	end

	// mode decode and per-lane control
	flight_mode_t mode;
	logic         manual;
	lane_ctl_t    ctl_rp, ctl_yaw;

	assign mode   = flight_mode_t'(s_tuser);
	assign manual = (mode == MODE_MANUAL);

	always_comb begin
		ctl_rp.zero  = manual;
		ctl_rp.scale = (mode == MODE_STAB) ? {3'd0, angle_q} : rate_q;
		ctl_yaw.zero  = manual;
		ctl_yaw.scale = rate_q;
	end

	// lanes
	logic signed [SP_W-1:0] roll_sp, pitch_sp, yaw_sp;
	logic [THR_W-1:0]       thr_lvl;

	rcss_lane u_roll (
		.clk      (clk),
		.en       (en),
		.pulse    (s_tdata[11:0]),
		.ctl      (ctl_rp),
		.deadband (deadband_q),
		.expo     (expo_q),
		.setpoint (roll_sp)
	);

	rcss_lane u_pitch (
		.clk      (clk),
		.en       (en),
		.pulse    (s_tdata[23:12]),
		.ctl      (ctl_rp),
		.deadband (deadband_q),
		.expo     (expo_q),
		.setpoint (pitch_sp)
	);

	rcss_lane u_yaw (
		.clk      (clk),
		.en       (en),
		.pulse    (s_tdata[35:24]),
		.ctl      (ctl_yaw),
		.deadband (deadband_q),
		.expo     (expo_q),
		.setpoint (yaw_sp)
	);

	rcss_throttle u_thr (
		.clk   (clk),
		.en    (en),
		.pulse (s_tdata[47:36]),
		.level (thr_lvl)
	);

	// valid flag travels beside the lanes
	logic [DEPTH-1:0] spv_q;

	always_ff @(posedge clk) begin
		if (en) begin
			spv_q <= {spv_q[DEPTH-2:0], !manual};
		end
	end

	// merge stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_q[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {3'd0, yaw_sp, pitch_sp, roll_sp, thr_lvl};
			m_tuser <= spv_q[DEPTH-1];
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the RC stick setpoint shaper
// Frames are sent on the input stream and each output beat is checked
// against an in-bench integer model of throttle mapping, deadband, expo and
// mode scaling. Register settings change between phases while the pipe is
// empty. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import rcss_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	typedef longint unsigned u64_t;

	// one predicted output beat
	typedef struct {
		logic [THR_W-1:0] throttle;
		logic [SP_W-1:0]  roll;
		logic [SP_W-1:0]  pitch;
		logic [SP_W-1:0]  yaw;
		logic             valid;
	} frame_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [79:0]           m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the block's registers
	logic [DB_W-1:0]    db_us     = DB_RST;
	logic [EXPO_W-1:0]  expo_e    = EXPO_RST;
	logic [ANGLE_W-1:0] angle_max = ANGLE_RST;
	logic [RATE_W-1:0]  rate_max  = RATE_RST;

	frame_result_t expected_setpoints[$];
	int  error_cnt = 0;
	int  cycle_cnt = 0;
	int  stall_left = 0;
	bit  src_idle_en = 1'b1;
	bit  snk_idle_en = 1'b1;

	rc_stick_setpoint_shaper_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len(bit en);
		int r;
		if (!en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// throttle: 1000..2000 us onto 0..1 in Q1.16, round half up, clamped
	function automatic logic [THR_W-1:0] throttle_of(logic [PULSE_W-1:0] p);
		longint unsigned t;
		if (p <= PULSE_MIN)
			return '0;
		if (p >= PULSE_MAX)
			return THR_W'(65536);
		t = ((u64_t'(p) - 1000) << 16) + 500;
		t = t / 1000;
		return t[THR_W-1:0];
	endfunction

	// one stick: center, deadband, normalize to Q1.15, expo, scale to Q12.8
	function automatic logic [SP_W-1:0] stick_setpoint(logic [PULSE_W-1:0] p,
			logic [RATE_W-1:0] scale);
		int ofs;
		longint unsigned a, m, g, f, y, mag, neg_mag;
		ofs = int'(p) - int'(PULSE_MID);
		a = u64_t'(ofs < 0 ? -ofs : ofs);
		if (a < db_us)
			a = 0;
		if (a > HALF_SPAN)
			a = HALF_SPAN;
		m = (a * 32768 + 250) / 500;
		g = (u64_t'(expo_e) * (Q30_ONE - m * m)) >> 16;
		f = Q30_ONE - g;
		y = (m * f) >> 30;
		mag = (y * scale + 64) >> 7;
		neg_mag = 64'd0 - mag;
		return (ofs < 0) ? neg_mag[SP_W-1:0] : mag[SP_W-1:0];
	endfunction

	function automatic frame_result_t shape_frame(logic [PULSE_W-1:0] roll,
			logic [PULSE_W-1:0] pitch, logic [PULSE_W-1:0] yaw,
			logic [PULSE_W-1:0] thr, flight_mode_t mode);
		frame_result_t sp;
		logic [RATE_W-1:0] rp_scale;
		sp.throttle = throttle_of(thr);
		if (mode == MODE_MANUAL) begin
			sp.roll  = '0;
			sp.pitch = '0;
			sp.yaw   = '0;
			sp.valid = 1'b0;
			return sp;
		end
		// stabilize scales roll/pitch by angle, everything else by rate
		rp_scale = (mode == MODE_STAB) ? RATE_W'(angle_max) : rate_max;
		sp.roll  = stick_setpoint(roll, rp_scale);
		sp.pitch = stick_setpoint(pitch, rp_scale);
		sp.yaw   = stick_setpoint(yaw, rate_max);
		sp.valid = 1'b1;
		return sp;
	endfunction

	// register write; caller sits at a falling edge
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEADBAND: db_us     = data[DB_W-1:0];
			REG_EXPO:     expo_e    = data[EXPO_W-1:0];
			REG_ANGLE:    angle_max = data[ANGLE_W-1:0];
			REG_RATE:     rate_max  = data[RATE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// one frame beat plus a random gap; valid stays high when no gap follows
	task automatic send_frame(logic [PULSE_W-1:0] roll, logic [PULSE_W-1:0] pitch,
			logic [PULSE_W-1:0] yaw, logic [PULSE_W-1:0] thr, flight_mode_t mode);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {thr, yaw, pitch, roll};
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		expected_setpoints.push_back(shape_frame(roll, pitch, yaw, thr, mode));
		@(negedge clk);
		gap = gap_len(src_idle_en);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// drop valid and let every expected beat come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_setpoints.size() != 0)
			@(negedge clk);
	endtask

	// sink readiness with random stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_left = gap_len(snk_idle_en);
		end
	end

	// output beat checker
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_setpoints.size() == 0) begin
				$error("output beat with nothing expected");
				error_cnt++;
			end else begin
				want = expected_setpoints.pop_front();
				if (m_tdata[16:0] !== want.throttle) begin
					$error("throttle_level expected %0d got %0d",
						want.throttle, m_tdata[16:0]);
					error_cnt++;
				end
				if (m_tdata[36:17] !== want.roll) begin
					$error("roll_setpoint expected %0d got %0d",
						$signed(want.roll), $signed(m_tdata[36:17]));
					error_cnt++;
				end
				if (m_tdata[56:37] !== want.pitch) begin
					$error("pitch_setpoint expected %0d got %0d",
						$signed(want.pitch), $signed(m_tdata[56:37]));
					error_cnt++;
				end
				if (m_tdata[76:57] !== want.yaw) begin
					$error("yaw_rate_setpoint expected %0d got %0d",
						$signed(want.yaw), $signed(m_tdata[76:57]));
					error_cnt++;
				end
				if (m_tuser[0] !== want.valid) begin
					$error("setpoints_valid expected %0d got %0d",
						want.valid, m_tuser[0]);
					error_cnt++;
				end
			end
		end
	end

	// reset values: stick and throttle extremes, deadband edges, all modes
	task automatic test_reset_defaults();
		send_frame(12'd1500, 12'd1500, 12'd1500, 12'd1000, MODE_STAB);
		send_frame(12'd0, 12'd4095, 12'd0, 12'd4095, MODE_STAB);
		send_frame(12'd1000, 12'd2000, 12'd1000, 12'd2000, MODE_ACRO);
		send_frame(12'd1519, 12'd1520, 12'd1481, 12'd999, MODE_ACRO);
		send_frame(12'd1480, 12'd1501, 12'd1999, 12'd1001, MODE_ACRO_X);
		send_frame(12'd2000, 12'd1000, 12'd2001, 12'd1999, MODE_MANUAL);
		send_frame(12'd4095, 12'd4095, 12'd4095, 12'd0, MODE_MANUAL);
		send_frame(12'd1750, 12'd1250, 12'd1600, 12'd1500, MODE_STAB);
		wait_drained();
	endtask

	// register extremes: linear, full expo, dead stick, masked bits, zero scale
	task automatic test_register_extremes();
		write_reg(REG_DEADBAND, 16'd0);
		write_reg(REG_EXPO, 16'd0);
		write_reg(REG_ANGLE, 16'd1);
		write_reg(REG_RATE, 16'd1);
		send_frame(12'd1501, 12'd1499, 12'd2000, 12'd1500, MODE_STAB);
		send_frame(12'd1000, 12'd2000, 12'd1700, 12'd1200, MODE_ACRO);
		wait_drained();

		// all ones: deadband 511 kills sticks within 511 us of center, largest scales
		write_reg(REG_DEADBAND, 16'hFFFF);
		write_reg(REG_EXPO, 16'hFFFF);
		write_reg(REG_ANGLE, 16'hFFFF);
		write_reg(REG_RATE, 16'hFFFF);
		send_frame(12'd4095, 12'd0, 12'd2010, 12'd1800, MODE_ACRO);
		wait_drained();
		// upper bits only: deadband lands on zero
		write_reg(REG_DEADBAND, 16'hFE00);
		send_frame(12'd2000, 12'd1000, 12'd4095, 12'd2000, MODE_STAB);
		send_frame(12'd0, 12'd4095, 12'd1000, 12'd1000, MODE_ACRO);
		wait_drained();

		// zero scale gives zero setpoints
		write_reg(REG_ANGLE, 16'd0);
		write_reg(REG_RATE, 16'd0);
		send_frame(12'd2000, 12'd1000, 12'd2000, 12'd1500, MODE_STAB);
		send_frame(12'd2000, 12'd1000, 12'd1000, 12'd1500, MODE_ACRO);
		wait_drained();
	endtask

	// random raw data on some writes exercises the dropped upper bits
	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(int lo, int hi);
		if ($urandom_range(0, 7) == 0)
			return CFG_DATA_W'($urandom);
		return CFG_DATA_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [PULSE_W-1:0] pick_pulse(int kind);
		int band;
		if (kind == 0)
			return PULSE_W'($urandom);
		if (kind == 1) begin
			// hover around the deadband edge
			band = int'(db_us) + 3;
			return PULSE_W'(int'(PULSE_MID) + $urandom_range(0, 2 * band) - band);
		end
		return PULSE_W'($urandom_range(950, 2050));
	endfunction

	// random register settings per phase, random frames inside each
	task automatic test_random_frames();
		int kind;
		for (int phase = 0; phase < 8; phase++) begin
			src_idle_en = (phase % 4 == 0) || (phase % 4 == 2);
			snk_idle_en = (phase % 4 == 0) || (phase % 4 == 3);
			write_reg(REG_DEADBAND, pick_reg_value(0, 60));
			write_reg(REG_EXPO, pick_reg_value(0, 65535));
			write_reg(REG_ANGLE, pick_reg_value(1, 180));
			write_reg(REG_RATE, pick_reg_value(1, 2000));
			for (int n = 0; n < 50; n++) begin
				kind = $urandom_range(0, 9);
				send_frame(pick_pulse(kind), pick_pulse(kind), pick_pulse(kind),
					pick_pulse(kind), flight_mode_t'($urandom_range(0, 3)));
			end
			wait_drained();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_frames();

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_cnt == 0 && expected_setpoints.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
